@@ rtl/prsq_pkg.sv @@
// Shared types, codes and sizes for the per-receiver send queues.
package prsq_pkg;

    localparam int NUM_QUEUES  = 64;
    localparam int QUEUE_DEPTH = 16;

    localparam int ID_W   = 6;
    localparam int QID_W  = 6;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int Q_W    = $clog2(NUM_QUEUES);
    localparam int S_W    = $clog2(QUEUE_DEPTH);
    localparam int E_W    = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int PTR_W  = 2 * S_W;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [QID_W-1:0] queue_id;
        logic [ID_W-1:0]  sender_id;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]   popped_id;
        logic [STAT_W-1:0] status;
        logic              queue_empty;
    } result_t;

    typedef struct packed {
        logic capture;
        logic evaluate;
        logic load_pop;
    } dp_cmd_t;

    typedef struct packed {
        logic pop_hit;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_FETCH  = 4'b0100,
        S_REPLY  = 4'b1000
    } state_t;

endpackage

@@ rtl/per_receiver_send_queues.sv @@
// Top level of the per-receiver send queues: controller plus datapath.
//
// An item is taken when start is high while busy is low. Busy then stays high
// and the result appears on result, marked by done for exactly one cycle in
// the reply state, which follows the lookup state (and, for a pop that returns
// an id, a fetch state that waits on the registered read of the entry store).
// The next item is taken only once the controller is back in idle: the
// pointer store and entry store are single memories with a registered read,
// and each item reads and then updates them in turn. The result cannot be
// held off; capture it in the cycle done is high. All queues are empty right
// out of reset, with no clearing pass.
module per_receiver_send_queues (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  prsq_pkg::item_t   item,
    output logic              busy,
    output logic              done,
    output prsq_pkg::result_t result
);
    import prsq_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    prsq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dp_stat (dp_stat),
        .dp_cmd  (dp_cmd),
        .busy    (busy),
        .done    (done)
    );

    prsq_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat),
        .result  (result)
    );

endmodule

@@ rtl/prsq_ram.sv @@
// Generic single-port-write, registered-read RAM.
module prsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/prsq_ctrl.sv @@
// Controller state machine that sequences one item through lookup, fetch (for a successful pop) and reply.
module prsq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  prsq_pkg::dp_stat_t dp_stat,
    output prsq_pkg::dp_cmd_t  dp_cmd,
    output logic               busy,
    output logic               done
);
    import prsq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = dp_stat.pop_hit ? S_FETCH : S_REPLY;
            end
            S_FETCH:  state_next = S_REPLY;
            S_REPLY:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = (state_reg == S_REPLY);
    assign dp_cmd.capture   = (state_reg == S_IDLE) && start;
    assign dp_cmd.evaluate  = (state_reg == S_LOOKUP);
    assign dp_cmd.load_pop  = (state_reg == S_FETCH);

endmodule

@@ rtl/prsq_dpath.sv @@
// Datapath: queue pointers, empty flags, entry store and result registers.
module prsq_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  prsq_pkg::item_t    item,
    input  prsq_pkg::dp_cmd_t  dp_cmd,
    output prsq_pkg::dp_stat_t dp_stat,
    output prsq_pkg::result_t  result
);
    import prsq_pkg::*;

    logic [CMD_W-1:0]      cmd_reg;
    logic [QID_W-1:0]      qid_reg;
    logic [ID_W-1:0]       sid_reg;
    logic [NUM_QUEUES-1:0] empty_reg;
    logic [NUM_QUEUES-1:0] empty_next;
    logic [ID_W-1:0]       popped_reg;
    logic [STAT_W-1:0]     status_reg;
    logic                  qempty_reg;

    logic [Q_W-1:0]   qidx;
    logic             in_range;
    logic             is_empty;
    logic [PTR_W-1:0] ptr_rdata;
    logic [PTR_W-1:0] ptr_wdata;
    logic             ptr_we;
    logic [S_W-1:0]   head;
    logic [S_W-1:0]   tail;
    logic [S_W-1:0]   tail_nx;
    logic [S_W-1:0]   head_nx;
    logic [E_W-1:0]   base;
    logic             ent_we;
    logic [S_W-1:0]   ent_wslot;
    logic [ID_W-1:0]  ent_rdata;
    logic [STAT_W-1:0] status_calc;
    logic             empty_after;
    logic             set_empty;
    logic             clr_empty;

    function automatic logic [S_W-1:0] next_slot(input logic [S_W-1:0] s);
        logic [S_W-1:0] r;
        if (s == S_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + S_W'(1);
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg <= item.command;
            qid_reg <= item.queue_id;
            sid_reg <= item.sender_id;
        end
        if (dp_cmd.evaluate)
        begin
            status_reg <= status_calc;
            qempty_reg <= empty_after;
            popped_reg <= '0;
        end
        else if (dp_cmd.load_pop)
        begin
            popped_reg <= ent_rdata;
        end
    end

    assign qidx     = qid_reg[Q_W-1:0];
    assign in_range = (32'(qid_reg) < NUM_QUEUES);
    assign is_empty = empty_reg[qidx];
    assign head     = ptr_rdata[PTR_W-1:S_W];
    assign tail     = ptr_rdata[S_W-1:0];
    assign tail_nx  = next_slot(tail);
    assign head_nx  = next_slot(head);
    assign base     = E_W'(qidx) * E_W'(QUEUE_DEPTH);

    // Decide the step from the pointers read at accept time
    always_comb
    begin
        status_calc = STAT_DONE;
        ptr_we      = 1'b0;
        ptr_wdata   = '0;
        ent_we      = 1'b0;
        ent_wslot   = '0;
        set_empty   = 1'b0;
        clr_empty   = 1'b0;
        dp_stat.pop_hit = 1'b0;
        case (cmd_reg)
            CMD_PUSH:
            begin
                if (!in_range)
                begin
                    status_calc = STAT_FULL;
                end
                else if (is_empty)
                begin
                    ptr_we    = 1'b1;
                    clr_empty = 1'b1;
                    ent_we    = 1'b1;
                end
                else if (tail_nx == head)
                begin
                    status_calc = STAT_FULL;
                end
                else
                begin
                    ptr_we    = 1'b1;
                    ptr_wdata = {head, tail_nx};
                    ent_we    = 1'b1;
                    ent_wslot = tail_nx;
                end
            end
            CMD_POP:
            begin
                if (!in_range || is_empty)
                begin
                    status_calc = STAT_EMPTY;
                end
                else
                begin
                    dp_stat.pop_hit = 1'b1;
                    ptr_we          = 1'b1;
                    // Last entry leaves: restart both pointers at slot zero
                    if (head == tail)
                    begin
                        set_empty = 1'b1;
                    end
                    else
                    begin
                        ptr_wdata = {head_nx, tail};
                    end
                end
            end
            default:
            begin
                status_calc = STAT_DONE;
            end
        endcase
    end

    assign empty_after = !in_range || set_empty || (is_empty && !clr_empty);

    always_comb
    begin
        empty_next = empty_reg;
        if (dp_cmd.evaluate && in_range)
        begin
            if (set_empty)
            begin
                empty_next[qidx] = 1'b1;
            end
            else if (clr_empty)
            begin
                empty_next[qidx] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= '1;
        end
        else
        begin
            empty_reg <= empty_next;
        end
    end

    // Pointer store is read at the incoming queue id so data is ready in lookup
    prsq_ram #(
        .WIDTH (PTR_W),
        .DEPTH (NUM_QUEUES)
    ) u_ptr_ram (
        .clk   (clk),
        .we    (dp_cmd.evaluate && ptr_we),
        .waddr (qidx),
        .wdata (ptr_wdata),
        .raddr (item.queue_id[Q_W-1:0]),
        .rdata (ptr_rdata)
    );

    prsq_ram #(
        .WIDTH (ID_W),
        .DEPTH (NUM_QUEUES * QUEUE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (dp_cmd.evaluate && ent_we),
        .waddr (base + E_W'(ent_wslot)),
        .wdata (sid_reg),
        .raddr (base + E_W'(head)),
        .rdata (ent_rdata)
    );

    assign result.popped_id   = popped_reg;
    assign result.status      = status_reg;
    assign result.queue_empty = qempty_reg;

endmodule
